// File: rtl/assert_macros.svh
// Assertion helpers for the height grid block.
// Each check is clocked on i_clk and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPLY(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("same-cycle check failed");
`define CHK_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define CHK_IMPLY(lbl, a, b)
`define CHK_NEXT(lbl, a, b)
`endif
`endif

// File: rtl/hgsr_pkg.sv
package hgsr_pkg;

    // Default grid geometry
    localparam int HGSR_GRID_COLS = 128;
    localparam int HGSR_GRID_ROWS = 128;
    localparam int HGSR_CELL_BITS = 16;

    // 1.0 in Q16.16
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Transaction modes
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_RANGE  = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Z  = 3'd1;
    localparam logic [2:0] REG_CPU_X     = 3'd2;
    localparam logic [2:0] REG_CPU_Z     = 3'd3;
    localparam logic [2:0] REG_BASE      = 3'd4;
    localparam logic [2:0] REG_SPAN      = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COORD,
        S_FETCH,
        S_BLEND,
        S_WALK,
        S_DRAIN,
        S_SCALE,
        S_DONE
    } t_state;

endpackage

// File: rtl/height_grid_sample_and_range.sv
// Height grid sampler. A write transaction (mode 0) is taken while busy
// stays low. A sample transaction (mode 1) strobes o_valid once its result
// is ready; a range transaction (mode 2) walks every cell of the clamped
// rectangle (one cell when the corners are reversed). The design has one
// shared 32x32 multiplier, used for the grid mapping, the bilinear blend and
// the height scaling, and the cell store has a single read port, which gives
// one cell a cycle. The result on o_height_low/o_height_high is marked by
// o_valid for one cycle only; the receiver must take it then. Cells must be
// written before they are read: the store has no reset.
`include "assert_macros.svh"
module height_grid_sample_and_range import hgsr_pkg::*; #(
    parameter int GRID_COLS = HGSR_GRID_COLS,
    parameter int GRID_ROWS = HGSR_GRID_ROWS,
    parameter int CELL_BITS = HGSR_CELL_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_corner_x,
    input  logic signed [31:0] i_corner_z,
    input  logic [6:0]         i_cell_col,
    input  logic [6:0]         i_cell_row,
    input  logic [15:0]        i_cell_value,
    output logic               o_valid,
    output logic signed [31:0] o_height_low,
    output logic signed [31:0] o_height_high,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW    = $clog2(GRID_COLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int MAXN  = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
    localparam int AXW   = $clog2(MAXN) + 1;
    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    localparam int MAW   = $clog2(DEPTH);
    localparam int YW    = CELL_BITS + 17;
    localparam logic [63:0] LIM_X = 64'(GRID_COLS) << 32;
    localparam logic [63:0] LIM_Z = 64'(GRID_ROWS) << 32;
    localparam logic [AXW-1:0] LAST_COL = AXW'(GRID_COLS - 1);
    localparam logic [AXW-1:0] LAST_ROW = AXW'(GRID_ROWS - 1);

    // Sequencer
    t_state r_state, n_state;
    logic [2:0] r_op, n_op;
    logic [1:0] r_ph, n_ph;
    logic       r_range;

    // Configuration
    logic [31:0] r_origin_x, r_origin_z, r_cpu_x, r_cpu_z, r_base, r_span;

    // Latched coordinates: point x, point z, corner x, corner z
    logic [31:0] r_pt [4];

    // Datapath
    logic [31:0]          r_d;
    logic                 r_dpos;
    logic [63:0]          r_prod;
    logic [CW-1:0]        r_col0, r_col1, r_walk_col;
    logic [RW-1:0]        r_row0, r_row1, r_walk_row;
    logic [15:0]          r_qx, r_qz;
    logic [CELL_BITS-1:0] r_cell [4];
    logic [YW-1:0]        r_y1, r_y2;
    logic [63:0]          r_acc;
    logic [32:0]          r_s;
    logic [31:0]          r_lo, r_hi;
    logic [CELL_BITS-1:0] r_least, r_greatest;
    logic                 r_first;

    // Cell store
    logic [CELL_BITS-1:0] r_mem [DEPTH];
    logic [CELL_BITS-1:0] r_rdata;
    logic                 r_rvld;
    logic [1:0]           r_rtag;

    logic                 accept;
    logic                 walk_done;
    logic [31:0]          mul_a, mul_b;
    logic                 rd_en;
    logic [CW-1:0]        rd_col;
    logic [RW-1:0]        rd_row;
    logic [1:0]           rd_tag;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign pready    = 1'b1;
    assign o_valid   = (r_state == S_DONE);
    assign o_height_low  = r_lo;
    assign o_height_high = r_hi;
    assign walk_done = (r_col0 > r_col1) || (r_row0 > r_row1)
                    || ((r_walk_col == r_col1) && (r_walk_row == r_row1));

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= 32'd0;
            r_origin_z <= 32'd0;
            r_cpu_x    <= 32'd65536;
            r_cpu_z    <= 32'd65536;
            r_base     <= 32'd0;
            r_span     <= 32'd65536;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_ORIGIN_X: r_origin_x <= pwdata;
                REG_ORIGIN_Z: r_origin_z <= pwdata;
                REG_CPU_X:    r_cpu_x    <= pwdata;
                REG_CPU_Z:    r_cpu_z    <= pwdata;
                REG_BASE:     r_base     <= pwdata;
                REG_SPAN:     r_span     <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (paddr[4:2])
            REG_ORIGIN_X: prdata = r_origin_x;
            REG_ORIGIN_Z: prdata = r_origin_z;
            REG_CPU_X:    prdata = r_cpu_x;
            REG_CPU_Z:    prdata = r_cpu_z;
            REG_BASE:     prdata = r_base;
            REG_SPAN:     prdata = r_span;
            default:      prdata = 32'd0;
        endcase
    end

    // Next state and step counters
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_ph    = r_ph;
        unique case (r_state)
            S_IDLE: begin
                n_op = 3'd0;
                n_ph = 2'd0;
                if (accept && (i_mode == MODE_SAMPLE || i_mode == MODE_RANGE)) begin
                    n_state = S_COORD;
                end
            end
            S_COORD: begin
                if (r_ph == 2'd2) begin
                    n_ph = 2'd0;
                    if (r_op == (r_range ? 3'd3 : 3'd1)) begin
                        n_op    = 3'd0;
                        n_state = r_range ? S_WALK : S_FETCH;
                    end else begin
                        n_op = r_op + 3'd1;
                    end
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            S_FETCH: begin
                if (r_op == 3'd3) begin
                    n_op    = 3'd0;
                    n_state = S_BLEND;
                end else begin
                    n_op = r_op + 3'd1;
                end
            end
            S_BLEND: begin
                if (r_ph == 2'd1) begin
                    n_ph = 2'd0;
                    if (r_op == 3'd7) begin
                        n_op    = 3'd0;
                        n_state = S_SCALE;
                    end else begin
                        n_op = r_op + 3'd1;
                    end
                end else begin
                    n_ph = 2'd1;
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_SCALE;
            end
            S_SCALE: begin
                if (r_ph == 2'd2) begin
                    n_ph = 2'd0;
                    if (r_op == (r_range ? 3'd1 : 3'd0)) begin
                        n_op    = 3'd0;
                        n_state = S_DONE;
                    end else begin
                        n_op = r_op + 3'd1;
                    end
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Multiplier operands and store reads per step
    always_comb begin
        mul_a  = 32'd0;
        mul_b  = 32'd0;
        rd_en  = 1'b0;
        rd_col = r_walk_col;
        rd_row = r_walk_row;
        rd_tag = 2'd0;
        unique case (r_state)
            S_COORD: begin
                mul_a = r_d;
                mul_b = r_op[0] ? r_cpu_z : r_cpu_x;
            end
            S_FETCH: begin
                rd_en  = 1'b1;
                rd_col = r_op[0] ? r_col1 : r_col0;
                rd_row = r_op[1] ? r_row1 : r_row0;
                rd_tag = r_op[1:0];
            end
            S_BLEND: begin
                unique case (r_op)
                    3'd0: begin
                        mul_a = 32'(ONE_Q16 - {1'b0, r_qx});
                        mul_b = 32'(r_cell[0]);
                    end
                    3'd1: begin
                        mul_a = 32'(r_qx);
                        mul_b = 32'(r_cell[1]);
                    end
                    3'd2: begin
                        mul_a = 32'(ONE_Q16 - {1'b0, r_qx});
                        mul_b = 32'(r_cell[2]);
                    end
                    3'd3: begin
                        mul_a = 32'(r_qx);
                        mul_b = 32'(r_cell[3]);
                    end
                    3'd4: begin
                        mul_a = 32'(ONE_Q16 - {1'b0, r_qz});
                        mul_b = 32'(r_y1);
                    end
                    3'd5: begin
                        mul_a = 32'(ONE_Q16 - {1'b0, r_qz});
                        mul_b = 32'(64'(r_y1) >> 32);
                    end
                    3'd6: begin
                        mul_a = 32'(r_qz);
                        mul_b = 32'(r_y2);
                    end
                    default: begin
                        mul_a = 32'(r_qz);
                        mul_b = 32'(64'(r_y2) >> 32);
                    end
                endcase
            end
            S_WALK: begin
                rd_en  = 1'b1;
                rd_tag = {1'b0, r_first};
            end
            S_SCALE: begin
                mul_b = r_span;
                if (!r_range) begin
                    mul_a = r_acc[CELL_BITS +: 32];
                end else if (r_op[0]) begin
                    mul_a = {r_greatest, {(32 - CELL_BITS){1'b0}}};
                end else begin
                    mul_a = {r_least, {(32 - CELL_BITS){1'b0}}};
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= 3'd0;
            r_ph    <= 2'd0;
            r_rvld  <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_ph    <= n_ph;
            r_rvld  <= rd_en;
            if (r_state == S_COORD && n_state == S_WALK) begin
                r_first <= 1'b1;
            end else if (r_state == S_WALK) begin
                r_first <= 1'b0;
            end
        end
    end

    // Cell store: write on a write transaction, read for the sequencer
    logic [31:0] wr_addr, rd_addr;
    logic [31:0] wr_val;
    assign wr_addr = 32'(i_cell_col) * 32'(GRID_ROWS) + 32'(i_cell_row);
    assign rd_addr = 32'(rd_col) * 32'(GRID_ROWS) + 32'(rd_row);
    assign wr_val  = 32'(i_cell_value);

    always_ff @(posedge i_clk) begin
        if (accept && i_mode == MODE_WRITE
                && 32'(i_cell_col) < 32'(GRID_COLS)
                && 32'(i_cell_row) < 32'(GRID_ROWS)) begin
            r_mem[wr_addr[MAW-1:0]] <= wr_val[CELL_BITS-1:0];
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr[MAW-1:0]];
        end
        r_rtag <= rd_tag;
    end

    // Grid mapping helpers for the coordinate consume step
    logic [32:0]    d33;
    logic [63:0]    lim, pmin;
    logic           g_ok;
    logic [AXW-1:0] ix, last_idx, cl0;
    logic [AXW:0]   ix1, cl1;
    logic [15:0]    q;
    logic [64:0]    rnd;
    logic [33:0]    h34;
    logic [31:0]    h_sat;
    logic [31:0]    sel_pt, sel_org;

    always_comb begin
        sel_pt   = r_pt[r_op[1:0]];
        sel_org  = r_op[0] ? r_origin_z : r_origin_x;
        d33      = {sel_pt[31], sel_pt} - {sel_org[31], sel_org};
        lim      = r_op[0] ? LIM_Z : LIM_X;
        pmin     = (r_prod > lim) ? lim : r_prod;
        g_ok     = r_dpos && ((r_op[0] ? r_cpu_z : r_cpu_x) != 32'd0);
        ix       = g_ok ? pmin[32 +: AXW] : '0;
        q        = g_ok ? pmin[31:16] : 16'd0;
        last_idx = r_op[0] ? LAST_ROW : LAST_COL;
        cl0      = (ix > last_idx) ? last_idx : ix;
        ix1      = {1'b0, ix} + 1'b1;
        cl1      = (ix1 > {1'b0, last_idx}) ? {1'b0, last_idx} : ix1;
        rnd      = {1'b0, r_prod} + 65'h0_8000_0000;
        h34      = {{2{r_base[31]}}, r_base} + {1'b0, r_s};
        if ($signed(h34) > 34'sd2147483647) begin
            h_sat = 32'h7FFF_FFFF;
        end else if ($signed(h34) < -34'sd2147483648) begin
            h_sat = 32'h8000_0000;
        end else begin
            h_sat = h34[31:0];
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, mul_a} * {32'd0, mul_b};

        // Latch the transaction
        if (accept) begin
            r_range <= (i_mode == MODE_RANGE);
            r_pt[0] <= i_point_x;
            r_pt[1] <= i_point_z;
            r_pt[2] <= i_corner_x;
            r_pt[3] <= i_corner_z;
        end

        // Map a coordinate to grid units and clamp its cell indices
        if (r_state == S_COORD) begin
            if (r_ph == 2'd0) begin
                r_d    <= d33[31:0];
                r_dpos <= !d33[32] && (d33 != 33'd0);
            end else if (r_ph == 2'd2) begin
                unique case (r_op[1:0])
                    2'd0: begin
                        r_col0 <= cl0[CW-1:0];
                        r_col1 <= cl1[CW-1:0];
                        r_qx   <= q;
                    end
                    2'd1: begin
                        r_row0 <= cl0[RW-1:0];
                        r_row1 <= cl1[RW-1:0];
                        r_qz   <= q;
                    end
                    2'd2: r_col1 <= cl0[CW-1:0];
                    default: r_row1 <= cl0[RW-1:0];
                endcase
            end
        end

        // Start the walk at the low corner
        if (r_state == S_COORD && n_state == S_WALK) begin
            r_walk_col <= r_col0;
            r_walk_row <= r_row0;
        end else if (r_state == S_WALK && !walk_done) begin
            if (r_walk_row == r_row1) begin
                r_walk_col <= r_walk_col + 1'b1;
                r_walk_row <= r_row0;
            end else begin
                r_walk_row <= r_walk_row + 1'b1;
            end
        end

        // Take returned cells
        if (r_rvld) begin
            if (!r_range) begin
                r_cell[r_rtag] <= r_rdata;
            end else if (r_rtag[0]) begin
                r_least    <= r_rdata;
                r_greatest <= r_rdata;
            end else begin
                if (r_rdata < r_least) begin
                    r_least <= r_rdata;
                end
                if (r_rdata > r_greatest) begin
                    r_greatest <= r_rdata;
                end
            end
        end

        // Accumulate the bilinear blend
        if (r_state == S_BLEND && r_ph == 2'd1) begin
            unique case (r_op)
                3'd0: r_y1 <= r_prod[YW-1:0];
                3'd1: r_y1 <= r_y1 + r_prod[YW-1:0];
                3'd2: r_y2 <= r_prod[YW-1:0];
                3'd3: r_y2 <= r_y2 + r_prod[YW-1:0];
                3'd4: r_acc <= r_prod;
                3'd6: r_acc <= r_acc + r_prod;
                default: r_acc <= r_acc + (r_prod << 32);
            endcase
        end

        // Scale into world height, round half up, saturate
        if (r_state == S_SCALE) begin
            if (r_ph == 2'd1) begin
                r_s <= rnd[64:32];
            end else if (r_ph == 2'd2) begin
                if (!r_range) begin
                    r_lo <= h_sat;
                    r_hi <= h_sat;
                end else if (r_op[0]) begin
                    r_hi <= h_sat;
                end else begin
                    r_lo <= h_sat;
                end
            end
        end
    end

    // Checks
    `CHK_NEXT(a_strobe_single, o_valid, !o_valid)
    `CHK_IMPLY(a_strobe_after_scale, o_valid, $past(r_state == S_SCALE))
    `CHK_NEXT(a_write_no_busy, accept && i_mode == MODE_WRITE, !busy)
    `CHK_IMPLY(a_walk_in_rows, r_state == S_WALK, r_walk_row >= r_row0)

endmodule

// File: tb/sv/hgsr_checker.sv
`timescale 1ns / 100ps
module hgsr_checker import hgsr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_corner_x,
    input  logic signed [31:0] i_corner_z,
    input  logic [6:0]         i_cell_col,
    input  logic [6:0]         i_cell_row,
    input  logic [15:0]        i_cell_value,
    input  logic               o_valid,
    input  logic signed [31:0] o_height_low,
    input  logic signed [31:0] o_height_high,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 o_fail_count,
    output int                 o_pending
);
    localparam int COLS = HGSR_GRID_COLS;
    localparam int ROWS = HGSR_GRID_ROWS;
    localparam int CBITS = HGSR_CELL_BITS;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_heights;

    logic [CBITS-1:0] grid_copy [COLS*ROWS];
    logic [31:0] org_x, org_z, cpu_x, cpu_z, base_y, span_y;
    t_heights heights_due [$];
    int mismatch_count;

    assign o_fail_count = mismatch_count;
    assign o_pending    = heights_due.size();

    // Map a world coordinate to Q16.16 grid units, clamped to the grid
    function automatic logic [63:0] grid_units(logic [31:0] coord, logic [31:0] org,
                                               logic [31:0] cpu, int cells);
        logic signed [63:0] d;
        logic [63:0] lim, p;
        d   = $signed({{32{coord[31]}}, coord}) - $signed({{32{org[31]}}, org});
        lim = 64'(cells) << 32;
        if (d <= 0 || cpu == 0) return 64'd0;
        if (64'(d) > lim / 64'(cpu)) p = lim;
        else p = 64'(d) * 64'(cpu);
        if (p > lim) p = lim;
        return p >> 16;
    endfunction

    function automatic int clamp_index(logic [63:0] i, int n);
        return (i > 64'(n - 1)) ? n - 1 : int'(i);
    endfunction

    function automatic logic [63:0] cell_at(int c, int r);
        return 64'(grid_copy[(c % COLS) * ROWS + (r % ROWS)]);
    endfunction

    // Scale a 0.32 fraction into world height with rounding and saturation
    function automatic logic signed [31:0] world_height(logic [63:0] t);
        logic [63:0] s;
        logic signed [63:0] w;
        s = (t * 64'(span_y) + 64'h8000_0000) >> 32;
        w = $signed({{32{base_y[31]}}, base_y}) + $signed(s);
        if (w > 64'sd2147483647) return 32'sh7fff_ffff;
        if (w < -64'sd2147483648) return 32'sh8000_0000;
        return w[31:0];
    endfunction

    function automatic t_heights sample_height();
        logic [63:0] gx, gz, qx, qz, y1, y2, y;
        int c0, c1, r0, r1;
        t_heights res;
        gx = grid_units(i_point_x, org_x, cpu_x, COLS);
        gz = grid_units(i_point_z, org_z, cpu_z, ROWS);
        qx = gx & 64'hffff;
        qz = gz & 64'hffff;
        c0 = clamp_index(gx >> 16, COLS);
        c1 = clamp_index((gx >> 16) + 1, COLS);
        r0 = clamp_index(gz >> 16, ROWS);
        r1 = clamp_index((gz >> 16) + 1, ROWS);
        y1 = (64'd65536 - qx) * cell_at(c0, r0) + qx * cell_at(c1, r0);
        y2 = (64'd65536 - qx) * cell_at(c0, r1) + qx * cell_at(c1, r1);
        y  = (64'd65536 - qz) * y1 + qz * y2;
        res.lo = world_height(y >> CBITS);
        res.hi = res.lo;
        return res;
    endfunction

    function automatic t_heights range_heights();
        int c0, c1, r0, r1;
        logic [63:0] least, most, h;
        t_heights res;
        c0 = clamp_index(grid_units(i_point_x, org_x, cpu_x, COLS) >> 16, COLS);
        r0 = clamp_index(grid_units(i_point_z, org_z, cpu_z, ROWS) >> 16, ROWS);
        c1 = clamp_index(grid_units(i_corner_x, org_x, cpu_x, COLS) >> 16, COLS);
        r1 = clamp_index(grid_units(i_corner_z, org_z, cpu_z, ROWS) >> 16, ROWS);
        least = cell_at(c0, r0);
        most  = least;
        for (int c = c0; c <= c1; c++) begin
            for (int r = r0; r <= r1; r++) begin
                h = cell_at(c, r);
                if (h < least) least = h;
                if (h > most) most = h;
            end
        end
        res.lo = world_height(least << (32 - CBITS));
        res.hi = world_height(most << (32 - CBITS));
        return res;
    endfunction

    // Track register writes and accepted transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            org_x <= '0; org_z <= '0; cpu_x <= 32'h10000; cpu_z <= 32'h10000;
            base_y <= '0; span_y <= 32'h10000;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    REG_ORIGIN_X: org_x  <= pwdata;
                    REG_ORIGIN_Z: org_z  <= pwdata;
                    REG_CPU_X:    cpu_x  <= pwdata;
                    REG_CPU_Z:    cpu_z  <= pwdata;
                    REG_BASE:     base_y <= pwdata;
                    REG_SPAN:     span_y <= pwdata;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                case (i_mode)
                    MODE_WRITE:  grid_copy[int'(i_cell_col) * ROWS + int'(i_cell_row)]
                                     = i_cell_value[CBITS-1:0];
                    MODE_SAMPLE: heights_due.push_back(sample_height());
                    MODE_RANGE:  heights_due.push_back(range_heights());
                    default: ;
                endcase
            end
        end
    end

    // Compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_heights want;
        if (!i_rst_n) begin
            mismatch_count <= 0;
        end else if (o_valid) begin
            if (heights_due.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result lo=%0d hi=%0d", o_height_low, o_height_high);
                mismatch_count <= mismatch_count + 1;
            end else begin
                want = heights_due.pop_front();
                if (want.lo !== o_height_low || want.hi !== o_height_high) begin
                    if (mismatch_count < 10)
                        $display("mismatch: expected lo=%0d hi=%0d, got lo=%0d hi=%0d",
                                 want.lo, want.hi, o_height_low, o_height_high);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end
endmodule

// File: tb/sv/tb_height_grid_sample_and_range.sv
`timescale 1ns / 100ps
module tb_height_grid_sample_and_range import hgsr_pkg::*; ();

    localparam int CYCLE_LIMIT = 5000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_mode;
    logic signed [31:0] i_point_x, i_point_z, i_corner_x, i_corner_z;
    logic [6:0]         i_cell_col, i_cell_row;
    logic [15:0]        i_cell_value;
    logic               o_valid;
    logic signed [31:0] o_height_low, o_height_high;
    logic               psel, penable, pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               pready;
    int                 fail_count, pending, cycle_count;
    int                 burst_left;

    height_grid_sample_and_range dut (.*);

    hgsr_checker checker_u (
        .i_clk, .i_rst_n, .start, .busy, .i_mode, .i_point_x, .i_point_z,
        .i_corner_x, .i_corner_z, .i_cell_col, .i_cell_row, .i_cell_value,
        .o_valid, .o_height_low, .o_height_high, .psel, .penable, .pwrite,
        .paddr, .pwdata, .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // Issue one transaction, idling between bursts
    task automatic issue(logic [1:0] m, logic [31:0] px, logic [31:0] pz,
                         logic [31:0] cx, logic [31:0] cz, logic [6:0] col,
                         logic [6:0] row, logic [15:0] val);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_mode = m; i_point_x = px; i_point_z = pz; i_corner_x = cx; i_corner_z = cz;
        i_cell_col = col; i_cell_row = row; i_cell_value = val; start = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // Random coordinate: mostly on the grid, sometimes anywhere
    function automatic logic [31:0] coord();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return $urandom_range(0, 132 << 16) - (2 << 16);
    endfunction

    task automatic fill_grid();
        for (int c = 0; c < 128; c++)
            for (int r = 0; r < 128; r++)
                issue(MODE_WRITE, 0, 0, 0, 0, 7'(c), 7'(r), 16'($urandom()));
    endtask

    task automatic random_items(int n);
        int pick;
        logic [31:0] px, pz;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            px = coord(); pz = coord();
            if (pick < 5)
                issue(MODE_SAMPLE, px, pz, 0, 0, 0, 0, 0);
            else if (pick < 8)
                // Mostly small rectangles so walks stay short
                issue(MODE_RANGE, px, pz, px + $urandom_range(0, 6 << 16) - (1 << 16),
                      pz + $urandom_range(0, 6 << 16) - (1 << 16), 0, 0, 0);
            else if (pick == 8)
                issue(MODE_WRITE, 0, 0, 0, 0, 7'($urandom()), 7'($urandom()),
                      16'($urandom()));
            else
                issue(MODE_NOP, $urandom(), $urandom(), $urandom(), $urandom(),
                      7'($urandom()), 7'($urandom()), 16'($urandom()));
        end
    endtask

    initial begin
        start = 1'b0; i_mode = MODE_WRITE; i_point_x = '0; i_point_z = '0;
        i_corner_x = '0; i_corner_z = '0; i_cell_col = '0; i_cell_row = '0;
        i_cell_value = '0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0; cycle_count = 0; burst_left = 0;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Every cell is written before any read
        fill_grid();

        // Directed: extremes, edge clamping, reversed corners, wide range
        issue(MODE_WRITE, 0, 0, 0, 0, 7'd0, 7'd0, 16'hffff);
        issue(MODE_WRITE, 0, 0, 0, 0, 7'd127, 7'd127, 16'h0000);
        issue(MODE_SAMPLE, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0, 0);
        issue(MODE_SAMPLE, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 0);
        issue(MODE_SAMPLE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 0);
        issue(MODE_SAMPLE, 32'h007f_8000, 32'h007f_c000, 0, 0, 0, 0, 0);
        issue(MODE_SAMPLE, 32'h0003_5555, 32'h0010_aaaa, 0, 0, 0, 0, 0);
        issue(MODE_RANGE, 32'h0005_0000, 32'h0005_0000, 32'h0002_0000, 32'h0009_0000,
              0, 0, 0);
        issue(MODE_RANGE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              0, 0, 0);
        issue(MODE_RANGE, 32'h007e_0000, 32'h007e_0000, 32'h7fff_ffff, 32'h7fff_ffff,
              0, 0, 0);
        issue(MODE_RANGE, 32'h8000_0000, 32'h8000_0000, 32'h0001_8000, 32'h0002_0000,
              0, 0, 0);
        issue(MODE_NOP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              7'h7f, 7'h7f, 16'hffff);
        issue(MODE_WRITE, 0, 0, 0, 0, 7'h55, 7'h2a, 16'h5a5a);
        issue(MODE_RANGE, 32'h0000_0000, 32'h0000_0000, 32'h0080_0000, 32'h0080_0000,
              0, 0, 0);
        wait_drained();

        // Several settings, including zero scale, huge scale and saturation
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    reg_write(REG_ORIGIN_X, 32'h8000_0000); reg_write(REG_ORIGIN_Z, 32'h7fff_ffff);
                    reg_write(REG_CPU_X, 32'h0);          reg_write(REG_CPU_Z, 32'hffff_ffff);
                    reg_write(REG_BASE, 32'h7fff_ffff);   reg_write(REG_SPAN, 32'hffff_ffff);
                end
                1: begin
                    reg_write(REG_ORIGIN_X, 32'hffff_0000); reg_write(REG_ORIGIN_Z, 32'h0001_0000);
                    reg_write(REG_CPU_X, 32'h0002_0000);  reg_write(REG_CPU_Z, 32'h0000_8000);
                    reg_write(REG_BASE, 32'h8000_0000);   reg_write(REG_SPAN, 32'h0);
                end
                2: begin
                    reg_write(REG_ORIGIN_X, 32'h0); reg_write(REG_ORIGIN_Z, 32'h0);
                    reg_write(REG_CPU_X, 32'h0001_0000); reg_write(REG_CPU_Z, 32'h0001_0000);
                    reg_write(REG_BASE, 32'h8000_0000); reg_write(REG_SPAN, 32'hffff_ffff);
                end
                default: begin
                    reg_write(REG_ORIGIN_X, $urandom_range(0, 8 << 16) - (4 << 16));
                    reg_write(REG_ORIGIN_Z, $urandom_range(0, 8 << 16) - (4 << 16));
                    reg_write(REG_CPU_X, $urandom_range(1 << 14, 3 << 16));
                    reg_write(REG_CPU_Z, $urandom_range(1 << 14, 3 << 16));
                    reg_write(REG_BASE, $urandom());
                    reg_write(REG_SPAN, $urandom());
                end
            endcase
            random_items(phase < 3 ? 150 : 400);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
